// ===== rtl/core/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants of the box overlap and correction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package aabb_pkg;

  localparam int QW   = 31;               // quotient / magnitude width
  localparam int DENW = 34;               // mass sum width
  localparam int NUMW = 63;               // dividend width
  localparam int INW  = 320;              // packed input bus width
  localparam int OUTW = 168;              // packed output bus width

  localparam logic [1:0] NRM_POS  = 2'b01;
  localparam logic [1:0] NRM_NEG  = 2'b11;
  localparam logic [1:0] NRM_ZERO = 2'b00;

  localparam logic [15:0] PCT_RESET  = 16'd13107;
  localparam logic [15:0] SLOP_RESET = 16'd655;

  localparam logic REG_PCT  = 1'b0;
  localparam logic REG_SLOP = 1'b1;

  // one box pair
  typedef struct packed {
    logic signed [31:0] a_left;
    logic signed [31:0] a_top;
    logic [30:0]        a_width;
    logic [30:0]        a_height;
    logic signed [31:0] b_left;
    logic signed [31:0] b_top;
    logic [30:0]        b_width;
    logic [30:0]        b_height;
    logic [31:0]        inv_mass_a;
    logic [31:0]        inv_mass_b;
  } pair_t;

  // contact info that rides along the divider
  typedef struct packed {
    logic          hit;
    logic [1:0]    nx;
    logic [1:0]    ny;
    logic [30:0]   pen;
    logic [QW-1:0] scaled;
    logic          sum_nz;
  } side_t;

  // divider entry
  typedef struct packed {
    side_t           side;
    logic [DENW-1:0] den;
    logic [NUMW-1:0] num;
  } div_in_t;

  // divider result
  typedef struct packed {
    side_t         side;
    logic [QW-1:0] quo;
    logic          rem_nz;
  } div_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/aabb_front.sv =====
// ----------------------------------------------------------------------------
// aabb_front
// Five-stage geometry front end: center offsets, overlaps, axis choice,
// slop removal, percent scaling and the mass-weighted dividend.
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_front import aabb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire pair_t       up_data,
  input  wire logic [15:0] pct,
  input  wire logic [15:0] slop,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output div_in_t          dn_data
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || dn_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign up_ready = en1;

  // stage 1: doubled center offsets and size sums
  logic signed [34:0] dx2_r, dy2_r;
  logic [31:0] wsum_r, hsum_r;
  logic [31:0] ima1_r, imb1_r;
  logic signed [34:0] cax, cay, cbx, cby;

  always_comb begin
    cax = {{2{up_data.a_left[31]}}, up_data.a_left, 1'b0} + $signed({4'b0, up_data.a_width});
    cbx = {{2{up_data.b_left[31]}}, up_data.b_left, 1'b0} + $signed({4'b0, up_data.b_width});
    cay = {{2{up_data.a_top[31]}}, up_data.a_top, 1'b0} + $signed({4'b0, up_data.a_height});
    cby = {{2{up_data.b_top[31]}}, up_data.b_top, 1'b0} + $signed({4'b0, up_data.b_height});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx2_r  <= cbx - cax;
      dy2_r  <= cby - cay;
      wsum_r <= {1'b0, up_data.a_width} + {1'b0, up_data.b_width};
      hsum_r <= {1'b0, up_data.a_height} + {1'b0, up_data.b_height};
      ima1_r <= up_data.inv_mass_a;
      imb1_r <= up_data.inv_mass_b;
    end
  end

  // stage 2: overlaps at doubled scale
  logic signed [34:0] ox2_r, oy2_r;
  logic dxneg_r, dyneg_r;
  logic [31:0] ima2_r, imb2_r;
  logic signed [34:0] adx, ady;

  always_comb begin
    adx = dx2_r[34] ? -dx2_r : dx2_r;
    ady = dy2_r[34] ? -dy2_r : dy2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ox2_r   <= $signed({3'b0, wsum_r}) - adx;
      oy2_r   <= $signed({3'b0, hsum_r}) - ady;
      dxneg_r <= dx2_r[34];
      dyneg_r <= dy2_r[34];
      ima2_r  <= ima1_r;
      imb2_r  <= imb1_r;
    end
  end

  // stage 3: hit test, axis choice (tie to y), slop removal, mass sum
  logic hit3_r;
  logic [1:0] nx3_r, ny3_r;
  logic [30:0] pen3_r, d3_r;
  logic [DENW-1:0] sum3_r;
  logic [31:0] ima3_r;
  logic hit_c, xsel;
  logic [30:0] pen_c;

  always_comb begin
    hit_c = !ox2_r[34] && (ox2_r != '0) && !oy2_r[34] && (oy2_r != '0);
    xsel  = ox2_r < oy2_r;
    pen_c = xsel ? ox2_r[31:1] : oy2_r[31:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      hit3_r <= hit_c;
      nx3_r  <= (hit_c && xsel) ? (dxneg_r ? NRM_POS : NRM_NEG) : NRM_ZERO;
      ny3_r  <= (hit_c && !xsel) ? (dyneg_r ? NRM_POS : NRM_NEG) : NRM_ZERO;
      pen3_r <= hit_c ? pen_c : '0;
      d3_r   <= (hit_c && pen_c > {15'b0, slop}) ? pen_c - {15'b0, slop} : '0;
      sum3_r <= {2'b0, ima2_r} + {2'b0, imb2_r};
      ima3_r <= ima2_r;
    end
  end

  // stage 4: percent scaling
  side_t side4_r;
  logic [DENW-1:0] sum4_r;
  logic [31:0] ima4_r;
  logic [46:0] pprod;

  assign pprod = {16'b0, d3_r} * {31'b0, pct};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      side4_r.hit    <= hit3_r;
      side4_r.nx     <= nx3_r;
      side4_r.ny     <= ny3_r;
      side4_r.pen    <= pen3_r;
      side4_r.scaled <= pprod[46:16];
      side4_r.sum_nz <= sum3_r != '0;
      sum4_r         <= sum3_r;
      ima4_r         <= ima3_r;
    end
  end

  // stage 5: dividend scaled * inv_mass_a
  div_in_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_r.side <= side4_r;
      out_r.den  <= sum4_r;
      out_r.num  <= {32'b0, side4_r.scaled} * {31'b0, ima4_r};
    end
  end

  assign dn_valid = v5_r;
  assign dn_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/aabb_div.sv =====
// ----------------------------------------------------------------------------
// aabb_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit QW bits, so the top dividend bits seed the remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_div import aabb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire div_in_t up_data,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output div_out_t     dn_data
);

  typedef struct packed {
    side_t           side;
    logic [DENW-1:0] den;
    logic [DENW-1:0] rem;
    logic [QW-1:0]   low;
    logic [QW-1:0]   quo;
  } dstg_t;

  dstg_t st_r [QW];
  logic  v_r  [QW];
  logic  en   [QW];
  dstg_t seed;

  // remainder seed: dividend bits above the quotient width
  always_comb begin
    seed.side = up_data.side;
    seed.den  = up_data.den;
    seed.rem  = {2'b0, up_data.num[NUMW-1:QW]};
    seed.low  = up_data.num[QW-1:0];
    seed.quo  = '0;
  end

  assign up_ready = en[0];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    dstg_t prev, nxt;
    logic  prev_v;
    logic [DENW:0] trial, diff;

    if (k == 0) begin : g_first
      assign prev   = seed;
      assign prev_v = up_valid;
    end else begin : g_next
      assign prev   = st_r[k-1];
      assign prev_v = v_r[k-1];
    end

    if (k == QW - 1) begin : g_last
      assign en[k] = !v_r[k] || dn_ready;
    end else begin : g_mid
      assign en[k] = !v_r[k] || en[k+1];
    end

    // one shift-subtract step
    always_comb begin
      trial    = {prev.rem, prev.low[QW-1]};
      diff     = trial - {1'b0, prev.den};
      nxt      = prev;
      nxt.low  = {prev.low[QW-2:0], 1'b0};
      if (trial >= {1'b0, prev.den}) begin
        nxt.rem = diff[DENW-1:0];
        nxt.quo = {prev.quo[QW-2:0], 1'b1};
      end else begin
        nxt.rem = trial[DENW-1:0];
        nxt.quo = {prev.quo[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign dn_valid       = v_r[QW-1];
  assign dn_data.side   = st_r[QW-1].side;
  assign dn_data.quo    = st_r[QW-1].quo;
  assign dn_data.rem_nz = st_r[QW-1].rem != '0;

endmodule
`default_nettype wire

// ===== rtl/core/aabb_overlap_correction.sv =====
// ----------------------------------------------------------------------------
// aabb_overlap_correction
// Box pair overlap test with mass-weighted positional correction.
// ----------------------------------------------------------------------------
// One box pair is taken per clock and one result leaves per clock, unless the
// output stalls. The path is five geometry/scaling stages, a 31-stage restoring
// divider (one quotient bit per stage, set by the 31-bit magnitude) and the
// output register. A single divide yields both magnitudes: B's is scaled minus
// A's, less one when the remainder is nonzero. Each stage holds its item under
// back-pressure and empty stages fill behind a stalled output.
`default_nettype none
module aabb_overlap_correction import aabb_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height,
  // inv_mass_a, inv_mass_b (from bit 0 up, zero padded)
  input  wire logic [INW-1:0]  in_tdata,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  // hit, normal_x, normal_y, penetration, shift_a_x, shift_a_y,
  // shift_b_x, shift_b_y (from bit 0 up, zero padded)
  output logic [OUTW-1:0]      out_tdata,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  input  wire logic            cfg_psel,
  input  wire logic            cfg_penable,
  input  wire logic            cfg_pwrite,
  input  wire logic [2:0]      cfg_paddr,
  input  wire logic [31:0]     cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  // configuration registers
  logic [15:0] pct_r, slop_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r  <= PCT_RESET;
      slop_r <= SLOP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_PCT:  pct_r  <= cfg_pwdata[15:0];
        REG_SLOP: slop_r <= cfg_pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_PCT:  cfg_prdata = {16'b0, pct_r};
      REG_SLOP: cfg_prdata = {16'b0, slop_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // input unpack
  pair_t pair;
  assign pair.a_left     = in_tdata[31:0];
  assign pair.a_top      = in_tdata[63:32];
  assign pair.a_width    = in_tdata[94:64];
  assign pair.a_height   = in_tdata[125:95];
  assign pair.b_left     = in_tdata[157:126];
  assign pair.b_top      = in_tdata[189:158];
  assign pair.b_width    = in_tdata[220:190];
  assign pair.b_height   = in_tdata[251:221];
  assign pair.inv_mass_a = in_tdata[283:252];
  assign pair.inv_mass_b = in_tdata[315:284];

  logic    f_valid, f_ready, d_valid, o_en;
  div_in_t f_data;
  div_out_t d_data;

  aabb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (pair),
    .pct      (pct_r),
    .slop     (slop_r),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_data  (f_data)
  );

  aabb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (d_valid),
    .dn_ready (o_en),
    .dn_data  (d_data)
  );

  // magnitudes and signed shifts
  logic [QW-1:0] mag_a, mag_b;
  logic signed [31:0] sax, say, sbx, sby;
  logic do_shift;

  function automatic logic signed [31:0] apply_nrm(input logic [1:0] n,
                                                   input logic [QW-1:0] m);
    logic signed [31:0] mm;
    mm = $signed({1'b0, m});
    unique case (n)
      NRM_POS: apply_nrm = mm;
      NRM_NEG: apply_nrm = -mm;
      default: apply_nrm = '0;
    endcase
  endfunction

  always_comb begin
    do_shift = d_data.side.hit && d_data.side.sum_nz;
    mag_a = do_shift ? d_data.quo : '0;
    mag_b = do_shift ? (d_data.side.scaled - d_data.quo - {{(QW-1){1'b0}}, d_data.rem_nz})
                     : '0;
    sax = apply_nrm(d_data.side.nx, mag_a);
    say = apply_nrm(d_data.side.ny, mag_a);
    sbx = -apply_nrm(d_data.side.nx, mag_b);
    sby = -apply_nrm(d_data.side.ny, mag_b);
  end

  // output register
  logic out_v_r;
  logic [OUTW-1:0] out_r;

  assign o_en = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_en) begin
      out_v_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      out_r <= {4'b0, sby, sbx, say, sax, d_data.side.pen,
                d_data.side.ny, d_data.side.nx, d_data.side.hit};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/aabb_checker.sv =====
// ----------------------------------------------------------------------------
// aabb_checker
// Port-level checks of the overlap pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_checker import aabb_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic [OUTW-1:0] out_tdata,
  input wire logic            out_tvalid,
  input wire logic            out_tready
);

  // stalled transfer holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OUTW-1:1] == '0)
    else $error("miss with nonzero fields");

  // a hit has exactly one nonzero normal component
  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      ((out_tdata[2:1] != 2'b00) != (out_tdata[4:3] != 2'b00)))
    else $error("hit without a single normal axis");

  // A and B never move the same way on x
  a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !((out_tdata[67] == out_tdata[131]) &&
                     (out_tdata[67:36] != '0) && (out_tdata[131:100] != '0)))
    else $error("shifts of A and B share a sign");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind aabb_overlap_correction aabb_checker u_aabb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire
